>>> design/ihp_pkg.sv
// ----------------------------------------------------------------------------
// ihp_pkg
// Shared constants and codes of the indexed min-heap.
// ----------------------------------------------------------------------------
package ihp_pkg;

    // id space and fixed field widths
    localparam int ID_SPACE      = 1024;
    localparam int ID_W          = 10;
    localparam int OP_W          = 2;
    localparam int STATUS_W      = 2;
    localparam int KEY_FIELD_W   = 32;
    localparam int POS_FIELD_W   = 10;
    localparam int COUNT_FIELD_W = 11;
    localparam int IN_DATA_W     = 48;
    localparam int OUT_DATA_W    = 64;

    // parameter defaults
    localparam int CAPACITY_DEF  = 1024;
    localparam int KEY_BITS_DEF  = 32;

    // operation codes
    typedef enum logic [OP_W-1:0] {
        OP_INSERT  = 2'd0,
        OP_CHANGE  = 2'd1,
        OP_EXTRACT = 2'd2,
        OP_LOOKUP  = 2'd3
    } op_t;

    // result status codes
    typedef enum logic [STATUS_W-1:0] {
        ST_OK     = 2'd0,
        ST_FULL   = 2'd1,
        ST_EMPTY  = 2'd2,
        ST_ID_BAD = 2'd3
    } status_t;

endpackage

>>> design/indexed_min_heap.sv
// ----------------------------------------------------------------------------
// indexed_min_heap
// Indexed binary min-heap of (id, key) entries with an id to position map.
// ----------------------------------------------------------------------------
// One operation per input beat: insert, change key, extract minimum or look
// up, each answered by one output beat. After reset the block clears the
// presence flags of all 1024 ids and takes no beat meanwhile. An operation
// runs under a small sequencer around key comparators and the dual-read
// heap memory. From one accepted beat to the next with the output free, it
// passes a check state, a state to read the entry for change key and
// lookup, a read and a compare state per level walked, the placement of
// the moved entry, the load of the output register and a return to idle.
// Change key walks up like insert or down like extract, by the new key.
// A new beat is taken only in idle, once the last result has been loaded
// into the output register. A result held back by the output side stalls
// the sequencer until the output register is free.
module indexed_min_heap
    import ihp_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF,
    parameter int KEY_BITS = KEY_BITS_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [IN_DATA_W-1:0]  s_tdata,   // entry_id, key, zero fill
    input  logic [OP_W-1:0]       s_tuser,   // op
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata,   // out_id, out_key, out_position,
                                             // entry_count, zero fill
    output logic [STATUS_W-1:0]   m_tuser    // status
);

    localparam int PW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = PW + 1;
    localparam int EW = ID_W + KEY_BITS;
    localparam int IAW = $clog2(ID_SPACE);

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_CHK, S_RDP, S_UP_RD, S_UP_CMP, S_DN_RD, S_DN_CMP, S_DONE
    } state_t;

    function automatic logic key_less(input logic [KEY_BITS-1:0] a,
                                      input logic [KEY_BITS-1:0] b);
        return $signed(a) < $signed(b);
    endfunction

    state_t              state_reg, state_next;
    op_t                 op_reg, op_next;
    logic [ID_W-1:0]     id_reg, id_next;
    logic [KEY_BITS-1:0] key_reg, key_next;
    logic [PW-1:0]       pos_reg, pos_next;
    logic [CW-1:0]       cnt_reg, cnt_next;
    logic [ID_W-1:0]     mid_reg, mid_next;
    logic [KEY_BITS-1:0] mkey_reg, mkey_next;
    logic [IAW-1:0]      clr_reg, clr_next;
    status_t             rst_reg, rst_next;
    logic [ID_W-1:0]     rid_reg, rid_next;
    logic [KEY_BITS-1:0] rkey_reg, rkey_next;
    logic [PW-1:0]       rpos_reg, rpos_next;
    logic                ov_reg, ov_next;
    status_t             ostat_reg;
    logic [ID_W-1:0]     oid_reg;
    logic [KEY_BITS-1:0] okey_reg;
    logic [PW-1:0]       opos_reg;
    logic [CW-1:0]       ocnt_reg;

    // memory ports
    logic            hp_we;
    logic [PW-1:0]   hp_wa, hp_ra, hp_rb;
    logic [EW-1:0]   hp_wd, hp_qa, hp_qb;
    logic            pm_we;
    logic [IAW-1:0]  pm_wa, pm_ra;
    logic [PW-1:0]   pm_wd, pm_q, pm_qb;
    logic            fl_we;
    logic [IAW-1:0]  fl_wa, fl_ra;
    logic            fl_wd, fl_q, fl_qb;

    ihp_ram #(.WIDTH(EW), .DEPTH(CAPACITY)) u_heap (
        .clk(clk), .we(hp_we), .waddr(hp_wa), .wdata(hp_wd),
        .raddr_a(hp_ra), .rdata_a(hp_qa), .raddr_b(hp_rb), .rdata_b(hp_qb)
    );

    ihp_ram #(.WIDTH(PW), .DEPTH(ID_SPACE)) u_pmap (
        .clk(clk), .we(pm_we), .waddr(pm_wa), .wdata(pm_wd),
        .raddr_a(pm_ra), .rdata_a(pm_q), .raddr_b(pm_ra), .rdata_b(pm_qb)
    );

    ihp_ram #(.WIDTH(1), .DEPTH(ID_SPACE)) u_flags (
        .clk(clk), .we(fl_we), .waddr(fl_wa), .wdata(fl_wd),
        .raddr_a(fl_ra), .rdata_a(fl_q), .raddr_b(fl_ra), .rdata_b(fl_qb)
    );

    // input field unpacking and key width adaption
    logic [ID_W-1:0]     in_id;
    logic [KEY_BITS-1:0] in_key;
    logic [KEY_FIELD_W-1:0] out_key_w;
    assign in_id = s_tdata[ID_W-1:0];

    generate
        if (KEY_BITS <= KEY_FIELD_W)
        begin : g_key_narrow
            assign in_key    = s_tdata[ID_W +: KEY_BITS];
            assign out_key_w = KEY_FIELD_W'($signed(okey_reg));
        end
        else
        begin : g_key_wide
            assign in_key    = KEY_BITS'($signed(s_tdata[ID_W +: KEY_FIELD_W]));
            assign out_key_w = okey_reg[KEY_FIELD_W-1:0];
        end
    endgenerate

    // heap entry fields and walk indexes
    logic [ID_W-1:0]     qa_id, qb_id;
    logic [KEY_BITS-1:0] qa_key, qb_key;
    logic [PW-1:0]       parent;
    logic [CW-1:0]       child_l, child_r;
    logic                take_r;
    assign qa_id   = hp_qa[ID_W-1:0];
    assign qa_key  = hp_qa[EW-1:ID_W];
    assign qb_id   = hp_qb[ID_W-1:0];
    assign qb_key  = hp_qb[EW-1:ID_W];
    assign parent  = (pos_reg - 1'b1) >> 1;
    assign child_l = {pos_reg, 1'b1};
    assign child_r = child_l + 1'b1;
    assign take_r  = (child_r < cnt_reg) && !key_less(qa_key, qb_key);

    assign s_tready = (state_reg == S_IDLE);

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        op_next    = op_reg;
        id_next    = id_reg;
        key_next   = key_reg;
        pos_next   = pos_reg;
        cnt_next   = cnt_reg;
        mid_next   = mid_reg;
        mkey_next  = mkey_reg;
        clr_next   = clr_reg;
        rst_next   = rst_reg;
        rid_next   = rid_reg;
        rkey_next  = rkey_reg;
        rpos_next  = rpos_reg;
        ov_next    = ov_reg;
        hp_we = 1'b0; hp_wa = pos_reg; hp_wd = {mkey_reg, mid_reg};
        hp_ra = '0;   hp_rb = PW'(cnt_reg - 1'b1);
        pm_we = 1'b0; pm_wa = mid_reg; pm_wd = pos_reg; pm_ra = in_id;
        fl_we = 1'b0; fl_wa = id_reg;  fl_wd = 1'b0;    fl_ra = in_id;

        if (ov_reg && m_tready)
        begin
            ov_next = 1'b0;
        end

        case (state_reg)
            S_CLEAR:
            begin
                fl_we = 1'b1;
                fl_wa = clr_reg;
                clr_next = clr_reg + 1'b1;
                if (clr_reg == IAW'(ID_SPACE - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    op_next    = op_t'(s_tuser);
                    id_next    = in_id;
                    key_next   = in_key;
                    state_next = S_CHK;
                end
            end
            S_CHK:
            begin
                rst_next  = ST_OK;
                rid_next  = id_reg;
                rkey_next = key_reg;
                rpos_next = '0;
                state_next = S_DONE;
                case (op_reg)
                    OP_INSERT:
                    begin
                        if (cnt_reg >= CW'(CAPACITY))
                        begin
                            rst_next = ST_FULL;
                        end
                        else if (fl_q)
                        begin
                            rst_next = ST_ID_BAD;
                        end
                        else
                        begin
                            fl_we = 1'b1; fl_wd = 1'b1;
                            cnt_next  = cnt_reg + 1'b1;
                            pos_next  = cnt_reg[PW-1:0];
                            mid_next  = id_reg;
                            mkey_next = key_reg;
                            state_next = S_UP_RD;
                        end
                    end
                    OP_CHANGE, OP_LOOKUP:
                    begin
                        if (!fl_q)
                        begin
                            rst_next = ST_ID_BAD;
                        end
                        else
                        begin
                            if (op_reg == OP_CHANGE && CW'(pm_q) >= cnt_reg)
                            begin
                                pos_next = '0;
                            end
                            else
                            begin
                                pos_next = pm_q;
                            end
                            hp_ra = pos_next;
                            state_next = S_RDP;
                        end
                    end
                    OP_EXTRACT:
                    begin
                        if (cnt_reg == '0)
                        begin
                            rst_next = ST_EMPTY;
                        end
                        else
                        begin
                            rid_next  = qa_id;
                            rkey_next = qa_key;
                            fl_we = 1'b1; fl_wa = qa_id;
                            cnt_next  = cnt_reg - 1'b1;
                            mid_next  = qb_id;
                            mkey_next = qb_key;
                            pos_next  = '0;
                            if (cnt_reg != CW'(1))
                            begin
                                state_next = S_DN_RD;
                            end
                        end
                    end
                    default:
                    begin
                        rst_next = ST_ID_BAD;
                    end
                endcase
                if (rst_next != ST_OK)
                begin
                    rid_next  = '0;
                    rkey_next = '0;
                end
            end
            S_RDP:
            begin
                if (op_reg == OP_LOOKUP)
                begin
                    rkey_next  = qa_key;
                    rpos_next  = pos_reg;
                    state_next = S_DONE;
                end
                else
                begin
                    mid_next  = qa_id;
                    mkey_next = key_reg;
                    state_next = key_less(key_reg, qa_key) ? S_UP_RD : S_DN_RD;
                end
            end
            S_UP_RD:
            begin
                if (pos_reg == '0)
                begin
                    hp_we = 1'b1; pm_we = 1'b1;
                    if (op_reg != OP_EXTRACT)
                    begin
                        rpos_next = pos_reg;
                    end
                    state_next = S_DONE;
                end
                else
                begin
                    hp_ra = parent;
                    state_next = S_UP_CMP;
                end
            end
            S_UP_CMP:
            begin
                hp_we = 1'b1; pm_we = 1'b1;
                if (key_less(qa_key, mkey_reg))
                begin
                    if (op_reg != OP_EXTRACT)
                    begin
                        rpos_next = pos_reg;
                    end
                    state_next = S_DONE;
                end
                else
                begin
                    hp_wd = hp_qa;
                    pm_wa = qa_id;
                    pos_next = parent;
                    state_next = S_UP_RD;
                end
            end
            S_DN_RD:
            begin
                if (child_l < cnt_reg)
                begin
                    hp_ra = child_l[PW-1:0];
                    hp_rb = child_r[PW-1:0];
                    state_next = S_DN_CMP;
                end
                else
                begin
                    state_next = S_UP_RD;
                end
            end
            S_DN_CMP:
            begin
                hp_we = 1'b1; pm_we = 1'b1;
                hp_wd = take_r ? hp_qb : hp_qa;
                pm_wa = take_r ? qb_id : qa_id;
                pos_next = take_r ? child_r[PW-1:0] : child_l[PW-1:0];
                state_next = S_DN_RD;
            end
            S_DONE:
            begin
                if (!ov_reg || m_tready)
                begin
                    ov_next = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            cnt_reg   <= '0;
            clr_reg   <= '0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            clr_reg   <= clr_next;
            ov_reg    <= ov_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        op_reg   <= op_next;
        id_reg   <= id_next;
        key_reg  <= key_next;
        pos_reg  <= pos_next;
        mid_reg  <= mid_next;
        mkey_reg <= mkey_next;
        rst_reg  <= rst_next;
        rid_reg  <= rid_next;
        rkey_reg <= rkey_next;
        rpos_reg <= rpos_next;
        if (state_reg == S_DONE && (!ov_reg || m_tready))
        begin
            ostat_reg <= rst_reg;
            oid_reg   <= rid_reg;
            okey_reg  <= rkey_reg;
            opos_reg  <= rpos_reg;
            ocnt_reg  <= cnt_reg;
        end
    end

    // output beat packing
    assign m_tvalid = ov_reg;
    assign m_tuser  = ostat_reg;
    assign m_tdata  = {1'b0, COUNT_FIELD_W'(ocnt_reg), POS_FIELD_W'(opos_reg),
                       out_key_w, oid_reg};

    // count never passes capacity
    a_cnt_cap: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CW'(CAPACITY))
        else $error("entry count above capacity");

    // count moves by at most one per edge
    a_cnt_step: assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_reg == $past(cnt_reg)) || (cnt_reg == $past(cnt_reg) + 1'b1) ||
        (cnt_reg + 1'b1 == $past(cnt_reg)))
        else $error("entry count jumped");

    // failed beats carry zero id and position
    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && ostat_reg != ST_OK) |-> (oid_reg == '0 && opos_reg == '0))
        else $error("failed result carries data");

    // full status only at capacity
    a_full: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && ostat_reg == ST_FULL) |-> (ocnt_reg == CW'(CAPACITY)))
        else $error("full status below capacity");

endmodule

>>> design/ihp_ram.sv
// ----------------------------------------------------------------------------
// ihp_ram
// Generic RAM: one write port, two read ports, registered read data.
// ----------------------------------------------------------------------------
module ihp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr_a,
    output logic [WIDTH-1:0]         rdata_a,
    input  logic [$clog2(DEPTH)-1:0] raddr_b,
    output logic [WIDTH-1:0]         rdata_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write and registered reads
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_a <= mem[raddr_a];
        rdata_b <= mem[raddr_b];
    end

endmodule

>>> tb/tb_indexed_min_heap.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_indexed_min_heap
// Self-checking bench for the indexed min-heap.
// ----------------------------------------------------------------------------
// A shadow heap with its own id to position map predicts each result beat.
// Directed beats cover empty, absent, duplicate, tie and extreme-key cases;
// then a random mix of operations runs on random keys with random gaps on
// both sides and one long output stall.
module tb_indexed_min_heap;
    import ihp_pkg::*;

    typedef struct packed {
        status_t     st;
        logic [9:0]  id;
        logic [31:0] key;
        logic [9:0]  pos;
        logic [10:0] cnt;
    } heap_result_t;

    // shadow heap and queue of predicted result beats
    class heap_scoreboard;
        logic [9:0]         slot_id [CAPACITY_DEF];
        logic signed [31:0] slot_key [CAPACITY_DEF];
        int                 where_is [ID_SPACE];
        bit                 held [ID_SPACE];
        int                 held_count;
        heap_result_t       pending [$];
        int                 errors;

        function void place(int p, logic [9:0] id, logic signed [31:0] k);
            slot_id[p] = id;
            slot_key[p] = k;
            where_is[id] = p;
        endfunction

        function int rise(int p);
            int up;
            logic [9:0] tid;
            logic signed [31:0] tkey;
            while (p > 0)
            begin
                up = (p - 1) / 2;
                if (slot_key[up] < slot_key[p]) break;
                tid = slot_id[up];
                tkey = slot_key[up];
                place(up, slot_id[p], slot_key[p]);
                place(p, tid, tkey);
                p = up;
            end
            return p;
        endfunction

        function int sink(int p);
            logic [9:0] mid;
            logic signed [31:0] mkey;
            int c;
            mid = slot_id[p];
            mkey = slot_key[p];
            c = 2 * p + 1;
            while (c < held_count)
            begin
                if (c + 1 < held_count && !(slot_key[c] < slot_key[c + 1])) c = c + 1;
                place(p, slot_id[c], slot_key[c]);
                p = c;
                c = 2 * p + 1;
            end
            place(p, mid, mkey);
            return rise(p);
        endfunction

        // apply one accepted operation and queue its result
        function void note(op_t op, logic [9:0] id, logic signed [31:0] k);
            heap_result_t r;
            int p;
            logic signed [31:0] old;
            r = '0;
            r.st = ST_OK;
            case (op)
                OP_INSERT:
                begin
                    if (held_count >= CAPACITY_DEF) r.st = ST_FULL;
                    else if (held[id]) r.st = ST_ID_BAD;
                    else
                    begin
                        p = held_count;
                        held_count++;
                        held[id] = 1;
                        place(p, id, k);
                        r.pos = 10'(rise(p));
                        r.id = id;
                        r.key = k;
                    end
                end
                OP_CHANGE:
                begin
                    if (!held[id]) r.st = ST_ID_BAD;
                    else
                    begin
                        p = where_is[id];
                        old = slot_key[p];
                        slot_key[p] = k;
                        r.pos = 10'((k < old) ? rise(p) : sink(p));
                        r.id = id;
                        r.key = k;
                    end
                end
                OP_EXTRACT:
                begin
                    if (held_count == 0) r.st = ST_EMPTY;
                    else
                    begin
                        r.id = slot_id[0];
                        r.key = slot_key[0];
                        held[slot_id[0]] = 0;
                        held_count--;
                        if (held_count > 0)
                        begin
                            place(0, slot_id[held_count], slot_key[held_count]);
                            void'(sink(0));
                        end
                    end
                end
                default:
                begin
                    if (!held[id]) r.st = ST_ID_BAD;
                    else
                    begin
                        p = where_is[id];
                        r.id = id;
                        r.key = slot_key[p];
                        r.pos = 10'(p);
                    end
                end
            endcase
            r.cnt = 11'(held_count);
            pending.push_back(r);
        endfunction

        function void check(heap_result_t got);
            heap_result_t want;
            if (pending.size() == 0)
            begin
                $error("result beat with nothing expected");
                errors++;
                return;
            end
            want = pending.pop_front();
            if (got.st !== want.st)
            begin
                $error("status: expected %0d, got %0d", want.st, got.st);
                errors++;
            end
            if (got.id !== want.id)
            begin
                $error("out_id: expected %0d, got %0d", want.id, got.id);
                errors++;
            end
            if (got.key !== want.key)
            begin
                $error("out_key: expected %0d, got %0d",
                       $signed(want.key), $signed(got.key));
                errors++;
            end
            if (got.pos !== want.pos)
            begin
                $error("out_position: expected %0d, got %0d", want.pos, got.pos);
                errors++;
            end
            if (got.cnt !== want.cnt)
            begin
                $error("entry_count: expected %0d, got %0d", want.cnt, got.cnt);
                errors++;
            end
        endfunction
    endclass

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int HOLD_CYCLES    = 400;

    logic                  clk;
    logic                  rst_n;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata;   // entry_id, key, zero fill
    logic [OP_W-1:0]       s_tuser;   // op
    logic                  m_tvalid;
    logic                  m_tready;
    logic [OUT_DATA_W-1:0] m_tdata;   // out_id, out_key, out_position, entry_count
    logic [STATUS_W-1:0]   m_tuser;   // status

    heap_scoreboard heap_sb;
    bit             steady_mode;
    bit             hold_req;
    int             quiet_cycles;

    indexed_min_heap i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // input beats update the shadow heap, output beats are checked
    always @(posedge clk)
    begin
        heap_result_t got;
        if (rst_n && s_tvalid && s_tready)
            heap_sb.note(op_t'(s_tuser), s_tdata[9:0], s_tdata[41:10]);
        if (rst_n && m_tvalid && m_tready)
        begin
            got.st  = status_t'(m_tuser);
            got.id  = m_tdata[9:0];
            got.key = m_tdata[41:10];
            got.pos = m_tdata[51:42];
            got.cnt = m_tdata[62:52];
            heap_sb.check(got);
        end
    end

    // watchdog on cycles without any beat
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // output ready with random stalls and one long hold-off on request
    initial
    begin
        int wait_cycles;
        m_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                m_tready = 1'b0;
                hold_req = 0;
                repeat (HOLD_CYCLES) @(negedge clk);
            end
            wait_cycles = steady_mode ? 0 : $urandom_range(0, 8);
            if (wait_cycles > 0)
            begin
                m_tready = 1'b0;
                repeat (wait_cycles) @(negedge clk);
            end
            m_tready = 1'b1;
            do @(posedge clk); while (!m_tvalid);
        end
    end

    task automatic send(op_t op, logic [9:0] id, logic [31:0] k);
        int gap;
        gap = steady_mode ? 0 : $urandom_range(0, 8);
        if (gap > 0)
        begin
            s_tvalid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tuser  = op;
        s_tdata  = {6'b0, k, id};
        s_tvalid = 1'b1;
        do @(posedge clk); while (!s_tready);
        @(negedge clk);
    endtask

    function automatic logic [31:0] pick_key();
        case ($urandom_range(0, 3))
            0: return $urandom;
            1: return $urandom_range(0, 16) - 8;
            2: return $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7fff_ffff;
            default: return $urandom_range(0, 3) * 1000;
        endcase
    endfunction

    function automatic logic [9:0] pick_id();
        return ($urandom_range(0, 3) == 0) ? 10'($urandom_range(0, 1023))
                                           : 10'($urandom_range(0, 31));
    endfunction

    initial
    begin
        int pick;
        heap_sb     = new();
        steady_mode = 0;
        hold_req    = 0;
        quiet_cycles = 0;
        rst_n    = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tuser  = OP_INSERT;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: empty heap, absent ids, duplicates, ties, extreme keys
        send(OP_EXTRACT, 10'd0, 32'd0);
        send(OP_LOOKUP, 10'd5, 32'd0);
        send(OP_CHANGE, 10'd5, 32'd1);
        send(OP_INSERT, 10'd0, 32'h8000_0000);
        send(OP_INSERT, 10'd1023, 32'h7fff_ffff);
        send(OP_INSERT, 10'd5, 32'd0);
        send(OP_INSERT, 10'd5, 32'd9);
        send(OP_INSERT, 10'd7, 32'd0);
        send(OP_LOOKUP, 10'd7, 32'd0);
        send(OP_CHANGE, 10'd7, 32'd50);
        send(OP_CHANGE, 10'd1023, 32'h8000_0000);
        send(OP_CHANGE, 10'd0, 32'h8000_0000);
        send(OP_LOOKUP, 10'd0, 32'd0);
        send(OP_LOOKUP, 10'd1023, 32'd0);
        repeat (4) send(OP_EXTRACT, 10'd0, 32'd0);
        send(OP_EXTRACT, 10'd0, 32'd0);

        // random mix with stretches of back-to-back beats
        for (int i = 0; i < 680; i++)
        begin
            if (i % 64 == 0) steady_mode = $urandom_range(0, 3) == 0;
            if (i == 100) hold_req = 1;
            pick = $urandom_range(0, 99);
            if (pick < 40) send(OP_INSERT, pick_id(), pick_key());
            else if (pick < 60) send(OP_CHANGE, pick_id(), pick_key());
            else if (pick < 85) send(OP_EXTRACT, pick_id(), pick_key());
            else send(OP_LOOKUP, pick_id(), pick_key());
        end
        s_tvalid = 1'b0;

        while (heap_sb.pending.size() != 0) @(posedge clk);
        repeat (100) @(posedge clk);
        if (heap_sb.errors == 0) $display("*** PASSED ***");
        else $display("*** FAILED ***");
        $finish;
    end

endmodule
